FILE: design/allocentric_panner_gains_top_defines.svh
// Assertion macros used by the controller (apg_ctrl).
`ifndef ALLOCENTRIC_PANNER_GAINS_TOP_DEFINES_SVH
`define ALLOCENTRIC_PANNER_GAINS_TOP_DEFINES_SVH

// Same-cycle implication, checked on clk_i, off during reset.
`define APG_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk_i, off during reset.
`define APG_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/apg_pkg.sv
package apg_pkg;

  localparam int MAX_SPEAKERS_DEF = 16;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEAKER_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GROUP_TOL     = 2'd1;

  localparam logic [4:0] SPK_COUNT_RST = 5'd16;
  localparam logic [9:0] GROUP_TOL_RST = 10'd16;

  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_COMPUTE = 1'b1;

  localparam logic [15:0] Q15_ONE = 16'h8000;

  // Axis codes
  localparam logic [1:0] AX_X = 2'd0;
  localparam logic [1:0] AX_Y = 2'd1;
  localparam logic [1:0] AX_Z = 2'd2;

  localparam int DIV_STEPS = 17;
  localparam int COS_STEPS = 5;

  localparam logic [30:0] CC1 = 31'd1324675879;
  localparam logic [30:0] CC2 = 31'd272375560;
  localparam logic [30:0] CC3 = 31'd22401994;
  localparam logic [30:0] CC4 = 31'd987048;
  localparam logic [30:0] CC5 = 31'd27060;

  typedef struct packed {
    logic              op;
    logic [3:0]        speaker_index;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic [15:0]       excluded_mask;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  out_speaker;
    logic [15:0] gain;
    logic [15:0] gain_x;
    logic [15:0] gain_y;
    logic [15:0] gain_z;
    logic        last;
  } out_item_t;

  typedef enum logic [3:0] {
    DP_NONE,
    DP_LOAD,
    DP_START,
    DP_CAPI,
    DP_AXSET,
    DP_DIV,
    DP_USQ,
    DP_CMUL,
    DP_CSUB,
    DP_CFIN,
    DP_P1,
    DP_P2,
    DP_P3,
    DP_OUT
  } dp_op_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RDI,
    S_CAPI,
    S_SCAN,
    S_SCANE,
    S_AXSET,
    S_DIV,
    S_USQ,
    S_CMUL,
    S_CSUB,
    S_CFIN,
    S_P1,
    S_P2,
    S_P3,
    S_OUT
  } state_e;

  typedef struct packed {
    dp_op_e     op;
    logic [1:0] ax;
    logic [3:0] spk;
    logic       last;
    logic [2:0] k;
    logic       rd_en;
    logic [3:0] rd_addr;
    logic       scan;
  } cmd_t;

  typedef struct packed {
    logic [3:0] n_last;
    logic       i_avail;
    logic       ax_div;
    logic       t_special;
    logic       out_free;
  } status_t;

  function automatic logic signed [16:0] off17(logic signed [15:0] a,
                                               logic signed [15:0] b);
    return {a[15], a} - {b[15], b};
  endfunction

  function automatic logic [16:0] abs17(logic signed [16:0] v);
    return v[16] ? 17'(~v + 17'd1) : 17'(v);
  endfunction

  // {positive, negative}
  function automatic logic [1:0] sgn3(logic signed [16:0] v);
    return {(!v[16]) && (v != 17'sd0), v[16]};
  endfunction

  function automatic logic [30:0] cos_coef(logic [2:0] k);
    logic [30:0] c;
    unique case (k)
      3'd0:    c = CC4;
      3'd1:    c = CC3;
      3'd2:    c = CC2;
      3'd3:    c = CC1;
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

FILE: design/apg_ctrl.sv
module apg_ctrl import apg_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  logic    in_op_i,
  input  status_t status_i,
  output logic    in_stall_o,
  output cmd_t    cmd_o
);

  `include "allocentric_panner_gains_top_defines.svh"

  state_e     state_q, state_d;
  logic [3:0] i_q, i_d;
  logic [3:0] j_q, j_d;
  logic [1:0] ax_q, ax_d;
  logic [4:0] cnt_q, cnt_d;
  logic [2:0] k_q, k_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      i_q     <= '0;
      j_q     <= '0;
      ax_q    <= '0;
      cnt_q   <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      j_q     <= j_d;
      ax_q    <= ax_d;
      cnt_q   <= cnt_d;
      k_q     <= k_d;
    end
  end

  // next state and counters
  always_comb begin
    state_d = state_q;
    i_d     = i_q;
    j_d     = j_q;
    ax_d    = ax_q;
    cnt_d   = cnt_q;
    k_d     = k_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i && (in_op_i == OP_COMPUTE)) begin
          i_d     = '0;
          state_d = S_RDI;
        end
      end
      S_RDI: state_d = S_CAPI;
      S_CAPI: begin
        j_d     = '0;
        state_d = status_i.i_avail ? S_SCAN : S_OUT;
      end
      S_SCAN: begin
        if (j_q == status_i.n_last) begin
          state_d = S_SCANE;
        end else begin
          j_d = j_q + 4'd1;
        end
      end
      S_SCANE: begin
        ax_d    = AX_X;
        state_d = S_AXSET;
      end
      S_AXSET: begin
        if (status_i.ax_div) begin
          cnt_d   = '0;
          state_d = S_DIV;
        end else if (ax_q == AX_Z) begin
          state_d = S_P1;
        end else begin
          ax_d    = ax_q + 2'd1;
        end
      end
      S_DIV: begin
        if (cnt_q == 5'(DIV_STEPS - 1)) begin
          state_d = S_USQ;
        end else begin
          cnt_d = cnt_q + 5'd1;
        end
      end
      S_USQ: begin
        k_d = '0;
        if (!status_i.t_special) begin
          state_d = S_CMUL;
        end else if (ax_q == AX_Z) begin
          state_d = S_P1;
        end else begin
          ax_d    = ax_q + 2'd1;
          state_d = S_AXSET;
        end
      end
      S_CMUL: state_d = S_CSUB;
      S_CSUB: begin
        if (k_q == 3'(COS_STEPS - 1)) begin
          state_d = S_CFIN;
        end else begin
          k_d     = k_q + 3'd1;
          state_d = S_CMUL;
        end
      end
      S_CFIN: begin
        if (ax_q == AX_Z) begin
          state_d = S_P1;
        end else begin
          ax_d    = ax_q + 2'd1;
          state_d = S_AXSET;
        end
      end
      S_P1: state_d = S_P2;
      S_P2: state_d = S_P3;
      S_P3: state_d = S_OUT;
      S_OUT: begin
        if (status_i.out_free) begin
          if (i_q == status_i.n_last) begin
            state_d = S_IDLE;
          end else begin
            i_d     = i_q + 4'd1;
            state_d = S_RDI;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd_o         = '0;
    cmd_o.op      = DP_NONE;
    cmd_o.ax      = ax_q;
    cmd_o.spk     = i_q;
    cmd_o.k       = k_q;
    cmd_o.last    = (i_q == status_i.n_last);
    cmd_o.rd_addr = i_q;
    in_stall_o    = (state_q != S_IDLE);
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = (in_op_i == OP_COMPUTE) ? DP_START : DP_LOAD;
        end
      end
      S_RDI:   cmd_o.rd_en = 1'b1;
      S_CAPI:  cmd_o.op = DP_CAPI;
      S_SCAN: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_addr = j_q;
        cmd_o.scan    = 1'b1;
      end
      S_SCANE: cmd_o.op = DP_NONE;
      S_AXSET: cmd_o.op = DP_AXSET;
      S_DIV:   cmd_o.op = DP_DIV;
      S_USQ:   cmd_o.op = DP_USQ;
      S_CMUL:  cmd_o.op = DP_CMUL;
      S_CSUB:  cmd_o.op = DP_CSUB;
      S_CFIN:  cmd_o.op = DP_CFIN;
      S_P1:    cmd_o.op = DP_P1;
      S_P2:    cmd_o.op = DP_P2;
      S_P3:    cmd_o.op = DP_P3;
      S_OUT: begin
        if (status_i.out_free) cmd_o.op = DP_OUT;
      end
      default: cmd_o.op = DP_NONE;
    endcase
  end

  `APG_ASSERT_IMP(a_out_free, cmd_o.op == DP_OUT, status_i.out_free, "result beat overwritten")
  `APG_ASSERT_NXT(a_last_idle, cmd_o.op == DP_OUT && cmd_o.last, state_q == S_IDLE,
                  "not idle after last result")
  `APG_ASSERT_IMP(a_scan_rng, state_q == S_SCAN, j_q <= status_i.n_last, "scan past count")

endmodule

FILE: design/apg_dp.sv
module apg_dp import apg_pkg::*; #(
  parameter int MaxSpeakers = MAX_SPEAKERS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  in_item_t              in_item_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  cmd_t                  cmd_i,
  output status_t               status_o,
  input  logic                  out_stall_i,
  output logic                  out_valid_o,
  output out_item_t             out_item_o
);

  localparam int AW  = (MaxSpeakers > 1) ? $clog2(MaxSpeakers) : 1;
  localparam int Lim = (MaxSpeakers < 16) ? MaxSpeakers : 16;

  // config
  logic [4:0] spk_cnt_q;
  logic [9:0] tol_q;
  logic [3:0] n_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spk_cnt_q <= SPK_COUNT_RST;
      tol_q     <= GROUP_TOL_RST;
    end else if (cfg_we_i) begin
      if (cfg_index_i == CFG_SPEAKER_COUNT) spk_cnt_q <= cfg_data_i[4:0];
      if (cfg_index_i == CFG_GROUP_TOL)     tol_q     <= cfg_data_i[9:0];
    end
  end

  always_comb begin
    if (spk_cnt_q == 5'd0) n_last = 4'd0;
    else if (int'(spk_cnt_q) > Lim) n_last = 4'(Lim - 1);
    else n_last = 4'(spk_cnt_q - 5'd1);
  end

  // position store
  logic signed [15:0] mem_x [MaxSpeakers];
  logic signed [15:0] mem_y [MaxSpeakers];
  logic signed [15:0] mem_z [MaxSpeakers];
  logic signed [15:0] rdx_q, rdy_q, rdz_q;
  logic [3:0]         rd_idx_q;
  logic               scan_v_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == DP_LOAD && int'(in_item_i.speaker_index) < MaxSpeakers) begin
      mem_x[AW'(in_item_i.speaker_index)] <= in_item_i.pos_x;
      mem_y[AW'(in_item_i.speaker_index)] <= in_item_i.pos_y;
      mem_z[AW'(in_item_i.speaker_index)] <= in_item_i.pos_z;
    end
    if (cmd_i.rd_en) begin
      rdx_q    <= mem_x[AW'(cmd_i.rd_addr)];
      rdy_q    <= mem_y[AW'(cmd_i.rd_addr)];
      rdz_q    <= mem_z[AW'(cmd_i.rd_addr)];
      rd_idx_q <= cmd_i.rd_addr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) scan_v_q <= 1'b0;
    else         scan_v_q <= cmd_i.rd_en && cmd_i.scan;
  end

  // source and speaker i
  logic signed [15:0] srcx_q, srcy_q, srcz_q;
  logic [15:0]        mask_q;
  logic signed [15:0] piy_q, piz_q;
  logic signed [16:0] d_q [3];
  logic signed [16:0] o_q [3];
  logic [2:0]         found_q;
  logic [15:0]        gain_q [3];

  // scan compare
  logic signed [16:0] v [3];
  logic [2:0]         memb;
  logic [2:0]         hit;
  logic               plane;

  always_comb begin
    v[0]  = off17(rdx_q, srcx_q);
    v[1]  = off17(rdy_q, srcy_q);
    v[2]  = off17(rdz_q, srcz_q);
    plane = !mask_q[rd_idx_q] && (abs17(off17(rdz_q, piz_q)) <= {7'd0, tol_q});
    memb[2] = !mask_q[rd_idx_q];
    memb[1] = plane;
    memb[0] = plane && (abs17(off17(rdy_q, piy_q)) <= {7'd0, tol_q});
    for (int a = 0; a < 3; a++) begin
      if (!d_q[a][16]) hit[a] = (v[a] < d_q[a]) && (!found_q[a] || v[a] > o_q[a]);
      else             hit[a] = (v[a] > d_q[a]) && (!found_q[a] || v[a] < o_q[a]);
    end
  end

  // axis select
  logic signed [16:0] sel_d, sel_o;
  logic               sel_f;
  logic               ax_div;
  logic signed [17:0] od;
  logic [17:0]        den_w;
  logic [33:0]        num_w;

  always_comb begin
    unique case (cmd_i.ax)
      AX_X:    begin sel_d = d_q[0]; sel_o = o_q[0]; sel_f = found_q[0]; end
      AX_Y:    begin sel_d = d_q[1]; sel_o = o_q[1]; sel_f = found_q[1]; end
      default: begin sel_d = d_q[2]; sel_o = o_q[2]; sel_f = found_q[2]; end
    endcase
    ax_div = sel_f && (sgn3(sel_o) != sgn3(sel_d));
    od     = {sel_o[16], sel_o} - {sel_d[16], sel_d};
    den_w  = od[17] ? 18'(~od + 18'd1) : 18'(od);
    num_w  = {1'b0, abs17(sel_d), 16'd0} + {17'd0, den_w[17:1]};
  end

  // divider and cosine
  logic [17:0] den_q;
  logic [17:0] rem_q;
  logic [16:0] low_q;
  logic [16:0] quo_q;
  logic [18:0] trial;
  logic [29:0] u_q;
  logic [30:0] r_q;
  logic [60:0] prod_q;
  logic [31:0] pm_q;
  logic [15:0] g1_q;
  logic [31:0] usq;
  logic [31:0] cfin;
  logic [32:0] rnd;
  logic        t_special;

  always_comb begin
    trial     = {rem_q, low_q[16]};
    usq       = 32'(quo_q[15:0]) * 32'(quo_q[15:0]);
    cfin      = 32'(31'h4000_0000 - r_q) + 32'd16384;
    rnd       = 33'(pm_q) + 33'd16384;
    t_special = (quo_q == 17'd0) || quo_q[16];
  end

  logic [1:0] axi;
  assign axi = (cmd_i.ax == AX_X) ? 2'd0 : (cmd_i.ax == AX_Y) ? 2'd1 : 2'd2;

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      DP_START: begin
        srcx_q <= in_item_i.pos_x;
        srcy_q <= in_item_i.pos_y;
        srcz_q <= in_item_i.pos_z;
        mask_q <= in_item_i.excluded_mask;
      end
      DP_CAPI: begin
        piy_q   <= rdy_q;
        piz_q   <= rdz_q;
        d_q[0]  <= off17(rdx_q, srcx_q);
        d_q[1]  <= off17(rdy_q, srcy_q);
        d_q[2]  <= off17(rdz_q, srcz_q);
        found_q <= '0;
        for (int a = 0; a < 3; a++) gain_q[a] <= '0;
        pm_q    <= '0;
      end
      DP_AXSET: begin
        den_q <= den_w;
        rem_q <= {1'b0, num_w[33:17]};
        low_q <= num_w[16:0];
        quo_q <= '0;
        if (!sel_f) gain_q[axi] <= Q15_ONE;
        else if (!ax_div) gain_q[axi] <= '0;
      end
      DP_DIV: begin
        if (trial >= {1'b0, den_q}) begin
          rem_q <= 18'(trial - {1'b0, den_q});
          quo_q <= {quo_q[15:0], 1'b1};
        end else begin
          rem_q <= trial[17:0];
          quo_q <= {quo_q[15:0], 1'b0};
        end
        low_q <= {low_q[15:0], 1'b0};
      end
      DP_USQ: begin
        if (quo_q == 17'd0) gain_q[axi] <= Q15_ONE;
        else if (quo_q[16]) gain_q[axi] <= '0;
        u_q <= usq[31:2];
        r_q <= CC5;
      end
      DP_CMUL: prod_q <= 61'(r_q) * 61'(u_q);
      DP_CSUB: begin
        if (cmd_i.k == 3'(COS_STEPS - 1)) r_q <= prod_q[60:30];
        else r_q <= cos_coef(cmd_i.k) - prod_q[60:30];
      end
      DP_CFIN: begin
        if (r_q[30]) gain_q[axi] <= '0;
        else gain_q[axi] <= cfin[30:15];
      end
      DP_P1: pm_q <= 32'(gain_q[0]) * 32'(gain_q[1]);
      DP_P2: g1_q <= rnd[30:15];
      DP_P3: pm_q <= 32'(g1_q) * 32'(gain_q[2]);
      default: ;
    endcase
    if (scan_v_q) begin
      for (int a = 0; a < 3; a++) begin
        if (memb[a] && hit[a]) begin
          o_q[a]     <= v[a];
          found_q[a] <= 1'b1;
        end
      end
    end
  end

  // result register
  logic      out_valid_q;
  out_item_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (cmd_i.op == DP_OUT) out_valid_q <= 1'b1;
    else if (!out_stall_i) out_valid_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == DP_OUT) begin
      out_q.out_speaker <= cmd_i.spk;
      out_q.gain        <= rnd[30:15];
      out_q.gain_x      <= gain_q[0];
      out_q.gain_y      <= gain_q[1];
      out_q.gain_z      <= gain_q[2];
      out_q.last        <= cmd_i.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  always_comb begin
    status_o.n_last    = n_last;
    status_o.i_avail   = !mask_q[cmd_i.spk];
    status_o.ax_div    = ax_div;
    status_o.t_special = t_special;
    status_o.out_free  = !out_valid_q || !out_stall_i;
  end

endmodule

FILE: design/allocentric_panner_gains_top.sv
// Load beat: written to the position store when taken, no result.
// Compute beat: per speaker in use, an excluded speaker goes straight to its result;
// else a group scan, then per axis a 17-step divider and 5-step cosine on one multiplier.
// One item at a time: a new beat is taken only after the last compute beat has finished.
// Reset: async active low; speaker_count and group_tolerance to 16, position store undefined.
module allocentric_panner_gains_top import apg_pkg::*; #(
  parameter int MaxSpeakers = MAX_SPEAKERS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // input channel
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_item_t              in_item_i,
  // result channel
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_item_t             out_item_o,
  // configuration writes
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  // The controller walks speakers i in slot order. For each i it reads the
  // speaker's position, then streams every slot j in use through the compare logic to
  // find the nearest group offset per axis. Each axis then runs through the
  // shared restoring divider (one quotient bit per cycle) and the cosine
  // polynomial (one multiply, one subtract per term). Two Q1.15 multiplies
  // form the total gain, and the result beat lands in an output register.
  //
  // Input beats are taken only while the controller is idle; the last result
  // may still wait in the output register when the next beat is taken.

  cmd_t    cmd;
  status_t status;

  // Config registers are always writable; the user must write them only while idle, the block does not enforce it.
  assign cfg_ready_o = 1'b1;

  apg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_op_i    (in_item_i.op),
    .status_i   (status),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd)
  );

  apg_dp #(
    .MaxSpeakers (MaxSpeakers)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o)
  );

endmodule
